/* design/heading_hold_pid_drive_unit_defines.svh */
// Assertion macros for the heading-hold PID drive unit.
// Define ASSERT_OFF to compile the checks out; no other dependency.
`ifndef HEADING_HOLD_PID_DRIVE_UNIT_DEFINES_SVH
`define HEADING_HOLD_PID_DRIVE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// check at every clock edge outside reset
`define HHPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check at every clock edge, reset included
`define HHPD_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HHPD_ASSERT(label, prop, msg)
`define HHPD_ASSERT_RST(label, prop, msg)
`endif

`endif

/* design/hhpd_pkg.sv */
// Shared types, constants and saturation helpers for the heading-hold PID drive unit.
// No dependencies.
package hhpd_pkg;

    // pipeline stages, one word per stage
    localparam int NUM_STAGES = 7;
    localparam int S_IN    = 0;
    localparam int S_FOLD  = 1;
    localparam int S_WRAP  = 2;
    localparam int S_STATE = 3;
    localparam int S_PROD  = 4;
    localparam int S_SUM   = 5;
    localparam int S_OUT   = 6;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int GAIN_W     = 24;
    localparam int SMOOTH_W   = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_GAIN = 2'd3;

    // heading wrap: 360 degrees = 46080 = 45 * 2^10 counts
    localparam int HALF_TURN_M1 = 23039;
    localparam int TURN_DIV     = 45;
    localparam int RECIP_45     = 1456;   // floor(2^16 / 45), under-estimates the quotient
    localparam logic [22:0] WRAP_OFFSET = 23'(45 * 65536);

    typedef struct packed {
        logic [GAIN_W-1:0]   prop_gain;
        logic [GAIN_W-1:0]   integ_gain;
        logic [GAIN_W-1:0]   deriv_gain;
        logic [SMOOTH_W-1:0] smooth_gain;
    } gains_t;

    localparam gains_t GAINS_RST = '{
        prop_gain:   24'd4294967,
        integ_gain:  24'd214748,
        deriv_gain:  24'd8589935,
        smooth_gain: 16'd32768
    };

    typedef struct packed {
        logic               mode;
        logic signed [15:0] target_angle;
        logic signed [31:0] gyro_angle;
        logic signed [23:0] gyro_rate;
        logic signed [15:0] drive_command;
    } item_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctl_t;

    function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
        logic signed [15:0] r;
        if (v > 34'sd32767)
            r = 16'sh7FFF;
        else if (v < -34'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31])
            r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

/* design/hhpd_wrap.sv */
// Heading error wrap, two stages: fold modulo 45 turns, then reduce and re-centre.
// Depends on hhpd_pkg.
module hhpd_wrap (
    input  logic                clk,
    input  hhpd_pkg::pipe_ctl_t ctl,
    input  hhpd_pkg::item_t     item_in,
    output hhpd_pkg::item_t     item_out,
    output logic signed [15:0]  wrapped
);
    import hhpd_pkg::*;

    // stage 1: offset error, split off the low 10 bits, fold the rest (2^12 = 1 mod 45)
    logic signed [33:0] shifted_err;
    logic signed [23:0] turns;
    logic [22:0]        turns_pos;
    logic [12:0]        fold1;
    logic [12:0]        fold2;

    logic [12:0] fold_reg;
    logic [9:0]  frac_reg;
    item_t       item1_reg;

    assign shifted_err = 34'(item_in.target_angle) - 34'(item_in.gyro_angle)
                       + 34'(HALF_TURN_M1);
    assign turns     = shifted_err[33:10];
    assign turns_pos = 23'(turns) + WRAP_OFFSET;
    assign fold1     = 13'(turns_pos[11:0]) + 13'(turns_pos[22:12]);
    assign fold2     = 13'(fold1[11:0]) + 13'(fold1[12]);

    always_ff @(posedge clk)
    begin
        if (ctl.load[S_FOLD])
        begin
            fold_reg  <= fold2;
            frac_reg  <= shifted_err[9:0];
            item1_reg <= item_in;
        end
    end

    // stage 2: residue mod 45 by reciprocal, one correcting subtract
    logic [23:0]        quot_prod;
    logic [7:0]         quot;
    logic [12:0]        rem_wide;
    logic [6:0]         rem;
    logic [5:0]         digit;
    logic [15:0]        mod_val;
    logic signed [16:0] wrapped_wide;

    logic signed [15:0] wrapped_reg;
    item_t              item2_reg;

    assign quot_prod    = 24'(fold_reg) * 24'(RECIP_45);
    assign quot         = quot_prod[23:16];
    assign rem_wide     = fold_reg - 13'(quot) * 13'(TURN_DIV);
    assign rem          = rem_wide[6:0];
    assign digit        = (rem >= 7'(TURN_DIV)) ? 6'(rem - 7'(TURN_DIV)) : rem[5:0];
    assign mod_val      = {digit, frac_reg};
    assign wrapped_wide = $signed({1'b0, mod_val}) - 17'(HALF_TURN_M1);

    always_ff @(posedge clk)
    begin
        if (ctl.load[S_WRAP])
        begin
            wrapped_reg <= wrapped_wide[15:0];
            item2_reg   <= item1_reg;
        end
    end

    assign wrapped  = wrapped_reg;
    assign item_out = item2_reg;

endmodule

/* design/hhpd_state.sv */
// Loop state stage: saturating error sum and first-order drive smoothing, both cleared by a reset word.
// Depends on hhpd_pkg.
module hhpd_state (
    input  logic                           clk,
    input  logic                           rst_n,
    input  hhpd_pkg::pipe_ctl_t            ctl,
    input  hhpd_pkg::item_t                item_in,
    input  logic signed [15:0]             wrapped_in,
    input  logic [hhpd_pkg::SMOOTH_W-1:0]  smooth_gain,
    output hhpd_pkg::item_t                item_out,
    output logic signed [15:0]             wrapped_out,
    output logic signed [31:0]             error_sum,
    output logic signed [15:0]             smoothed_drive
);
    import hhpd_pkg::*;

    logic signed [32:0] esum_wide;
    logic signed [16:0] drive_diff;
    logic signed [33:0] smooth_prod;
    logic signed [17:0] smooth_step;
    logic signed [17:0] sd_wide;

    logic signed [31:0] error_sum_reg;
    logic signed [15:0] smoothed_drive_reg;
    logic signed [15:0] wrapped_reg;
    item_t              item_reg;

    assign esum_wide   = 33'(error_sum_reg) + 33'(wrapped_in);
    assign drive_diff  = 17'(item_in.drive_command) - 17'(smoothed_drive_reg);
    assign smooth_prod = $signed({1'b0, smooth_gain}) * drive_diff;
    assign smooth_step = smooth_prod[33:16];
    assign sd_wide     = 18'(smoothed_drive_reg) + smooth_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg      <= '0;
            smoothed_drive_reg <= '0;
        end
        else if (ctl.load[S_STATE])
        begin
            if (item_in.mode)
            begin
                error_sum_reg      <= '0;
                smoothed_drive_reg <= '0;
            end
            else
            begin
                error_sum_reg      <= sat32(esum_wide);
                smoothed_drive_reg <= sat16(34'(sd_wide));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[S_STATE])
        begin
            wrapped_reg <= wrapped_in;
            item_reg    <= item_in;
        end
    end

    assign error_sum      = error_sum_reg;
    assign smoothed_drive = smoothed_drive_reg;
    assign wrapped_out    = wrapped_reg;
    assign item_out       = item_reg;

endmodule

/* design/hhpd_turn.sv */
// PID turn path and tank mix: products, sum and clamp, then the output register.
// Depends on hhpd_pkg.
module hhpd_turn (
    input  logic                 clk,
    input  hhpd_pkg::pipe_ctl_t  ctl,
    input  hhpd_pkg::gains_t     gains,
    input  hhpd_pkg::item_t      item_in,
    input  logic signed [15:0]   wrapped_in,
    input  logic signed [31:0]   error_sum,
    input  logic signed [15:0]   smoothed_drive,
    output logic signed [15:0]   left_power,
    output logic signed [15:0]   right_power,
    output logic signed [15:0]   turn_power,
    output logic signed [15:0]   heading_error,
    output logic                 out_mode
);
    import hhpd_pkg::*;

    // stage 4: the three gain products
    logic signed [40:0] prod_p_next;
    logic signed [56:0] prod_i_next;
    logic signed [48:0] prod_d_next;

    logic signed [40:0] prod_p_reg;
    logic signed [56:0] prod_i_reg;
    logic signed [48:0] prod_d_reg;
    logic signed [15:0] wrapped4_reg;
    logic signed [15:0] sd4_reg;
    logic               mode4_reg;

    assign prod_p_next = $signed({1'b0, gains.prop_gain}) * wrapped_in;
    assign prod_i_next = $signed({1'b0, gains.integ_gain}) * error_sum;
    assign prod_d_next = $signed({1'b0, gains.deriv_gain}) * item_in.gyro_rate;

    always_ff @(posedge clk)
    begin
        if (ctl.load[S_PROD])
        begin
            prod_p_reg   <= prod_p_next;
            prod_i_reg   <= prod_i_next;
            prod_d_reg   <= prod_d_next;
            wrapped4_reg <= wrapped_in;
            sd4_reg      <= smoothed_drive;
            mode4_reg    <= item_in.mode;
        end
    end

    // stage 5: sum, floor shift by 24, clamp
    logic signed [57:0] acc;
    logic signed [33:0] turn_wide;

    logic signed [15:0] turn5_reg;
    logic signed [15:0] wrapped5_reg;
    logic signed [15:0] sd5_reg;
    logic               mode5_reg;

    assign acc       = 58'(prod_p_reg) + 58'(prod_i_reg) - 58'(prod_d_reg);
    assign turn_wide = acc[57:24];

    always_ff @(posedge clk)
    begin
        if (ctl.load[S_SUM])
        begin
            turn5_reg    <= sat16(turn_wide);
            wrapped5_reg <= wrapped4_reg;
            sd5_reg      <= sd4_reg;
            mode5_reg    <= mode4_reg;
        end
    end

    // stage 6: tank mix into the output register; a reset word gives all zeros
    logic signed [16:0] left_wide;
    logic signed [16:0] right_wide;

    logic signed [15:0] left_reg;
    logic signed [15:0] right_reg;
    logic signed [15:0] turn_reg;
    logic signed [15:0] error_reg;
    logic               mode_reg;

    assign left_wide  = 17'(turn5_reg) - 17'(sd5_reg);
    assign right_wide = 17'(sd5_reg) + 17'(turn5_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.load[S_OUT])
        begin
            mode_reg <= mode5_reg;
            if (mode5_reg)
            begin
                left_reg  <= '0;
                right_reg <= '0;
                turn_reg  <= '0;
                error_reg <= '0;
            end
            else
            begin
                left_reg  <= sat16(34'(left_wide));
                right_reg <= sat16(34'(right_wide));
                turn_reg  <= turn5_reg;
                error_reg <= wrapped5_reg;
            end
        end
    end

    assign left_power    = left_reg;
    assign right_power   = right_reg;
    assign turn_power    = turn_reg;
    assign heading_error = error_reg;
    assign out_mode      = mode_reg;

endmodule

/* design/heading_hold_pid_drive_unit.sv */
// Heading-hold PID drive unit, top level; uses hhpd_pkg, hhpd_wrap, hhpd_state, hhpd_turn.
// Each word passes in turn through the input, fold, wrap, state, products, sum and output registers.
// Throughput: one word per cycle when not stalled; the seven-stage pipeline (input, fold, wrap,
// state, products, sum, output) is the limit, and a bubble in any stage is closed up behind a stall.
// Reset (rst_n, asynchronous, active low): pipeline empty, error sum and smoothed drive zero,
// gains at their defaults. No clearing pass; a word can be accepted as soon as reset is released.
`include "heading_hold_pid_drive_unit_defines.svh"

module heading_hold_pid_drive_unit (
    input  logic                             clk,
    input  logic                             rst_n,

    // input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             mode,
    input  logic signed [15:0]               target_angle,
    input  logic signed [31:0]               gyro_angle,
    input  logic signed [23:0]               gyro_rate,
    input  logic signed [15:0]               drive_command,

    // result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [15:0]               left_power,
    output logic signed [15:0]               right_power,
    output logic signed [15:0]               turn_power,
    output logic signed [15:0]               heading_error,

    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hhpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hhpd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import hhpd_pkg::*;

    // ------------------------------------------------------------------
    // Gain registers. Always ready; a write lands at once, so write only
    // while no word is in flight.
    // ------------------------------------------------------------------
    gains_t gains_reg;
    gains_t gains_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        gains_next = gains_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PROP_GAIN:   gains_next.prop_gain   = cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN:  gains_next.integ_gain  = cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN:  gains_next.deriv_gain  = cfg_data[GAIN_W-1:0];
                REG_SMOOTH_GAIN: gains_next.smooth_gain = cfg_data[SMOOTH_W-1:0];
                default:         gains_next = gains_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gains_reg <= GAINS_RST;
        else
            gains_reg <= gains_next;
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage holds one valid bit. A stage may
    // load when it is empty or when the stage after it moves on, so a
    // stalled result only backs up the stages that are actually full.
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] stage_valid_reg;
    logic [NUM_STAGES-1:0] stage_valid_next;
    logic [NUM_STAGES-1:0] stage_ready;
    logic [NUM_STAGES-1:0] stage_feed;
    pipe_ctl_t             pipe_ctl;

    assign stage_feed = {stage_valid_reg[NUM_STAGES-2:0], in_valid};

    always_comb
    begin
        stage_ready[NUM_STAGES-1] = !stage_valid_reg[NUM_STAGES-1] || !out_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
            stage_ready[k] = !stage_valid_reg[k] || stage_ready[k+1];
    end

    always_comb
    begin
        pipe_ctl.load    = stage_ready & stage_feed;
        stage_valid_next = (stage_ready & stage_feed) | (~stage_ready & stage_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= '0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    assign in_stall  = !stage_ready[S_IN];
    assign out_valid = stage_valid_reg[S_OUT];

    // ------------------------------------------------------------------
    // Input register: capture the accepted word.
    // ------------------------------------------------------------------
    item_t in_item;
    item_t item0_reg;

    always_comb
    begin
        in_item.mode          = mode;
        in_item.target_angle  = target_angle;
        in_item.gyro_angle    = gyro_angle;
        in_item.gyro_rate     = gyro_rate;
        in_item.drive_command = drive_command;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_ctl.load[S_IN])
            item0_reg <= in_item;
    end

    // ------------------------------------------------------------------
    // Datapath: wrap the heading error, advance the loop state, then form
    // the turn command and mix it with the smoothed drive.
    // ------------------------------------------------------------------
    item_t              wrap_item;
    logic signed [15:0] wrap_error;
    item_t              state_item;
    logic signed [15:0] state_error;
    logic signed [31:0] error_sum;
    logic signed [15:0] smoothed_drive;
    logic               out_mode;

    hhpd_wrap u_wrap (
        .clk      (clk),
        .ctl      (pipe_ctl),
        .item_in  (item0_reg),
        .item_out (wrap_item),
        .wrapped  (wrap_error)
    );

    hhpd_state u_state (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (pipe_ctl),
        .item_in        (wrap_item),
        .wrapped_in     (wrap_error),
        .smooth_gain    (gains_reg.smooth_gain),
        .item_out       (state_item),
        .wrapped_out    (state_error),
        .error_sum      (error_sum),
        .smoothed_drive (smoothed_drive)
    );

    hhpd_turn u_turn (
        .clk            (clk),
        .ctl            (pipe_ctl),
        .gains          (gains_reg),
        .item_in        (state_item),
        .wrapped_in     (state_error),
        .error_sum      (error_sum),
        .smoothed_drive (smoothed_drive),
        .left_power     (left_power),
        .right_power    (right_power),
        .turn_power     (turn_power),
        .heading_error  (heading_error),
        .out_mode       (out_mode)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------

    // words in flight change only by acceptance and delivery
    `HHPD_ASSERT(a_word_count, ##1 $countones(stage_valid_reg) == $past($countones(stage_valid_reg)) + $past(in_valid && !in_stall) - $past(out_valid && !out_stall), "word lost or duplicated in pipeline")

    // a full pipeline behind a stalled result must push back on the input
    `HHPD_ASSERT(a_full_backpressure, (&stage_valid_reg && out_stall) |-> in_stall, "input taken while pipeline full and output stalled")

    // a reset word clears both loop states
    `HHPD_ASSERT(a_reset_word_clears, (pipe_ctl.load[S_STATE] && wrap_item.mode) |=> (error_sum == '0 && smoothed_drive == '0), "reset word left loop state set")

    // a delivered reset word carries all-zero fields
    `HHPD_ASSERT(a_reset_word_zero, (out_valid && out_mode) |-> (left_power == '0 && right_power == '0 && turn_power == '0 && heading_error == '0), "reset word result not zero")

    // reset empties the pipeline and clears the loop state by the next edge
    `HHPD_ASSERT_RST(a_reset_state, !rst_n |=> (stage_valid_reg == '0 && error_sum == '0 && smoothed_drive == '0), "state not cleared in reset")

endmodule
